// File: hw/rtl/hbnd_pkg.sv
// ============================================================================
// hbnd_pkg - shared types and helpers for the hires byte to dot colour block
// Holds the queue item layout, the half-dot counts and the colour lookup.
// ============================================================================
package hbnd_pkg;

    // Half-dots produced by one screen byte
    localparam int unsigned DOTS_PER_BYTE = 14;
    // Half-dots held back so that the four-dot window is known
    localparam int unsigned PEND_DOTS     = 3;
    // Widest half-dot run carried by one item (held-back dots plus one byte)
    localparam int unsigned RUN_W         = PEND_DOTS + DOTS_PER_BYTE;
    // Back-end window: the run padded with zero dots past the line end
    localparam int unsigned WIN_W         = RUN_W + PEND_DOTS;
    localparam int unsigned CNT_W         = 5;

    // Dots sent per byte: first byte of a line, middle byte, closing byte
    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(DOTS_PER_BYTE - PEND_DOTS);
    localparam logic [CNT_W-1:0] CNT_MID   = CNT_W'(DOTS_PER_BYTE);
    localparam logic [CNT_W-1:0] CNT_CLOSE = CNT_W'(RUN_W);

    // Display modes
    localparam logic MODE_MONO = 1'b0;
    localparam logic MODE_NTSC = 1'b1;

    localparam logic [3:0] COLOUR_BLACK = 4'd0;
    localparam logic [3:0] COLOUR_WHITE = 4'd15;

    // One classified byte, as queued between front and back
    typedef struct packed {
        logic [RUN_W-1:0] dots;    // half-dots, bit 0 the oldest
        logic [CNT_W-1:0] count;   // dots to send for this byte
        logic [1:0]       phase;   // line position of the first dot, mod 4
        logic             close;   // this byte ends the line
    } t_item;

    // Colour of one dot from its four-dot window (bit 0 is the dot itself)
    function automatic logic [3:0] colour_of(input logic mode, input logic [3:0] win,
                                             input logic [1:0] phase);
        logic [3:0] v;
        logic [3:0] c;
        v = {win[0], win[1], win[2], win[3]};
        unique case (phase)
            2'd0: c = v;
            2'd1: c = {v[0], v[3:1]};
            2'd2: c = {v[1:0], v[3:2]};
            2'd3: c = {v[2:0], v[3]};
            default: c = v;
        endcase
        if (mode == MODE_NTSC) begin
            colour_of = c;
        end else begin
            colour_of = win[0] ? COLOUR_WHITE : COLOUR_BLACK;
        end
    endfunction

endpackage

// File: hw/rtl/hires_byte_to_ntsc_dot_color.sv
// ============================================================================
// hires_byte_to_ntsc_dot_color - hires byte to artifact colour dot stream
// Top level: configuration register, intake, queue and dot sequencer.
// ============================================================================
// Each accepted screen byte becomes 14 half-dot results on average: 11 for
// the first byte of a line, 14 for a middle byte and 17 for the byte that
// closes a line (14 when a line is a single byte). The dot sequencer sends
// one result per clock unless the output stalls; the intake takes a new byte
// whenever the two-item queue has room. Results trail the input by three
// half-dots so the four-dot colour window is known; the rest of a line goes
// out on its final byte. The display mode register is sampled as each dot is
// sent. The user must write it only while idle; the block does not check.
module hires_byte_to_ntsc_dot_color #(
    parameter int unsigned BYTES_PER_LINE = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_screen_byte,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_dot_color,
    output logic       o_last_dot
);
    import hbnd_pkg::*;

    logic  r_display_mode;
    logic  in_accept;
    t_item front_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    // Hold the display mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= MODE_NTSC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_display_mode <= i_cfg_data;
        end
    end

    hbnd_front #(
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_screen_byte (i_screen_byte),
        .i_line_end    (i_line_end),
        .o_item        (front_item)
    );

    hbnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    hbnd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_display_mode),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dot_color (o_dot_color),
        .o_last_dot  (o_last_dot)
    );

endmodule

// File: hw/rtl/hbnd_front.sv
// ============================================================================
// hbnd_front - byte intake and classification
// Expands each accepted byte to half-dots, joins the held-back dots and
// tracks line position, then hands one item to the queue.
// ============================================================================
module hbnd_front #(
    parameter int unsigned BYTES_PER_LINE = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_screen_byte,
    input  logic             i_line_end,
    output hbnd_pkg::t_item  o_item
);
    import hbnd_pkg::*;

    localparam int unsigned BC_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
    localparam logic [BC_W-1:0] LAST_BYTE = BC_W'(BYTES_PER_LINE - 1);

    logic [BC_W-1:0]      r_byte_cnt;
    logic                 r_mid;       // held-back dots present
    logic [PEND_DOTS-1:0] r_pend;
    logic [1:0]           r_phase;
    logic                 r_prev_six;

    logic [DOTS_PER_BYTE-1:0] new_dots;
    logic                     close;
    logic [CNT_W-1:0]         count;

    // Spread the byte over fourteen half-dots, shifted by one when bit 7 is set
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            new_dots[2*i]   = i_screen_byte[i];
            new_dots[2*i+1] = i_screen_byte[i];
        end
        new_dots[12] = i_screen_byte[6];
        new_dots[13] = i_screen_byte[6];
        if (i_screen_byte[7]) begin
            new_dots = {new_dots[DOTS_PER_BYTE-2:0], r_prev_six};
        end
    end

    // Close the line on its flag or on the final byte slot
    assign close = i_line_end || (r_byte_cnt == LAST_BYTE);

    always_comb begin
        priority case (1'b1)
            r_mid && close:  count = CNT_CLOSE;
            r_mid || close:  count = CNT_MID;
            default:         count = CNT_FIRST;
        endcase
    end

    // Build the queue item
    always_comb begin
        o_item.dots  = r_mid ? {new_dots, r_pend} : {{PEND_DOTS{1'b0}}, new_dots};
        o_item.count = count;
        o_item.phase = r_phase;
        o_item.close = close;
    end

    // Advance line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_mid      <= 1'b0;
            r_pend     <= '0;
            r_phase    <= '0;
            r_prev_six <= 1'b0;
        end else if (i_accept) begin
            if (close) begin
                r_byte_cnt <= '0;
                r_mid      <= 1'b0;
                r_pend     <= '0;
                r_phase    <= '0;
                r_prev_six <= 1'b0;
            end else begin
                r_byte_cnt <= r_byte_cnt + BC_W'(1);
                r_mid      <= 1'b1;
                r_pend     <= new_dots[DOTS_PER_BYTE-1:DOTS_PER_BYTE-PEND_DOTS];
                r_phase    <= r_phase + count[1:0];
                r_prev_six <= i_screen_byte[6];
            end
        end
    end

    // A closed line leaves the front at line start
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && close |=> r_byte_cnt == '0 && !r_mid && r_phase == 2'd0)
        else $error("line state not cleared after line end");

endmodule

// File: hw/rtl/hbnd_queue.sv
// ============================================================================
// hbnd_queue - two-item queue between front and back
// Lets the intake keep taking bytes while the dot stream drains.
// ============================================================================
module hbnd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hbnd_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output hbnd_pkg::t_item  o_item
);
    import hbnd_pkg::*;

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/hbnd_back.sv
// ============================================================================
// hbnd_back - dot sequencer and colour stage
// Walks each queued item one dot a cycle, unless the output stalls, through
// a shifting four-dot window and registers the colour on the output channel.
// ============================================================================
module hbnd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_q_valid,
    input  hbnd_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [3:0]       o_dot_color,
    output logic             o_last_dot
);
    import hbnd_pkg::*;

    logic             r_busy;
    logic [WIN_W-1:0] r_win;
    logic [CNT_W-1:0] r_left;
    logic [1:0]       r_phase;
    logic             r_close;
    logic             r_out_valid;
    logic [3:0]       r_color;
    logic             r_last;

    logic out_load;
    logic emit;
    logic finishing;

    assign out_load  = !r_out_valid || !i_out_stall;
    assign emit      = r_busy && out_load;
    assign finishing = emit && (r_left == CNT_W'(1));
    assign o_q_pop   = i_q_valid && (!r_busy || finishing);

    assign o_out_valid = r_out_valid;
    assign o_dot_color = r_color;
    assign o_last_dot  = r_last;

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= emit;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_left <= i_q_item.count;
            end else if (finishing) begin
                r_busy <= 1'b0;
                r_left <= '0;
            end else if (emit) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    // Window, phase and output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_color <= colour_of(i_mode, r_win[3:0], r_phase);
            r_last  <= r_close && (r_left == CNT_W'(1));
        end
        if (o_q_pop) begin
            r_win   <= {{PEND_DOTS{1'b0}}, i_q_item.dots};
            r_phase <= i_q_item.phase;
            r_close <= i_q_item.close;
        end else if (emit) begin
            r_win   <= r_win >> 1;
            r_phase <= r_phase + 2'd1;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != '0)
        else $error("sequencer busy with no dots left");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - hires byte to NTSC dot colour stream
// Feeds screen bytes through the block under four idling phases and both
// display modes, predicts every dot from a local model of the half-dot
// expansion and colour window, and checks each dot in order as it leaves.
// ============================================================================
module testbench;
    import hbnd_pkg::*;

    localparam int LINE_BYTES  = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_LIMIT = 20;

    typedef struct packed {
        logic [7:0] screen_byte;
        logic       line_end;
    } t_screen_item;

    typedef struct packed {
        logic [3:0] colour;
        logic       last;
    } t_dot;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_screen_byte = 8'h00;
    logic       i_line_end = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [3:0] o_dot_color;
    logic       o_last_dot;

    // Items waiting to be sent and dots waiting to arrive
    t_screen_item bytes_pending[$];
    t_dot         dots_due[$];
    t_screen_item next_byte;

    // Local copy of the block's line state and display mode
    logic       disp_mode = MODE_NTSC;
    logic [2:0] held_dots = '0;
    logic [1:0] held_count = '0;
    logic [9:0] dot_pos = '0;
    logic       prev_bit_six = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int n_pushed = 0;
    int n_bytes = 0;
    int n_dots = 0;
    int n_lines = 0;
    int n_forced = 0;
    int n_mono = 0;
    int n_colour = 0;
    int n_writes = 0;
    int n_err = 0;
    int quiet_cycles = 0;
    bit progress;

    hires_byte_to_ntsc_dot_color #(
        .BYTES_PER_LINE(LINE_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_screen_byte(i_screen_byte),
        .i_line_end   (i_line_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_dot_color  (o_dot_color),
        .o_last_dot   (o_last_dot)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_err++;
        if (n_err <= PRINT_LIMIT) begin
            $display("%0t: dot %0d: %s: got %0d, expected %0d", $time, n_dots, what, got, want);
        end
    endtask

    // Expand one accepted byte into half-dots and queue the dots it releases
    function automatic void expand_byte(input logic [7:0] b, input logic line_end);
        logic [23:0] d;
        logic [3:0]  v;
        logic [7:0]  twice;
        int          n;
        int          cnt;
        int          bytes_done;
        int          r;
        logic        close;
        t_dot        e;
        d = '0;
        n = 0;
        close = line_end;
        bytes_done = (int'(dot_pos) + int'(held_count)) / DOTS_PER_BYTE;
        if (bytes_done + 1 >= LINE_BYTES) begin
            if (!line_end) n_forced++;
            close = 1'b1;
        end
        for (int i = 0; i < int'(held_count); i++) begin
            d[n] = held_dots[i];
            n++;
        end
        // Shifted byte: the previous bit six leads by one half-dot
        if (b[7]) begin
            d[n] = prev_bit_six;
            n++;
        end
        for (int i = 0; i < 6; i++) begin
            d[n]     = b[i];
            d[n + 1] = b[i];
            n += 2;
        end
        d[n] = b[6];
        n++;
        if (!b[7]) begin
            d[n] = b[6];
            n++;
        end
        // Hold back three half-dots unless the line closes here
        cnt = close ? n : n - int'(PEND_DOTS);
        for (int i = 0; i < cnt; i++) begin
            if (disp_mode == MODE_NTSC) begin
                v = {d[i], d[i + 1], d[i + 2], d[i + 3]};
                r = (int'(dot_pos) + i) % 4;
                twice = {v, v} >> r;
                e.colour = twice[3:0];
                n_colour++;
            end else begin
                e.colour = d[i] ? COLOUR_WHITE : COLOUR_BLACK;
                n_mono++;
            end
            e.last = close && (i == cnt - 1);
            dots_due.push_back(e);
        end
        if (close) begin
            held_dots = '0;
            held_count = '0;
            dot_pos = '0;
            prev_bit_six = 1'b0;
            n_lines++;
        end else begin
            held_dots = {d[n - 1], d[n - 2], d[n - 3]};
            held_count = 2'(PEND_DOTS);
            dot_pos = dot_pos + 10'(cnt);
            prev_bit_six = b[6];
        end
    endfunction

    // Driver: present the next item once the current one has gone
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (bytes_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                next_byte = bytes_pending.pop_front();
                i_in_valid <= 1'b1;
                i_screen_byte <= next_byte.screen_byte;
                i_line_end <= next_byte.line_end;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: follow config and input items, check dots, drive the stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            quiet_cycles = 0;
        end else begin
            progress = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                disp_mode = i_cfg_data;
                n_writes++;
                progress = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                expand_byte(i_screen_byte, i_line_end);
                n_bytes++;
                progress = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (dots_due.size() == 0) begin
                    report_mismatch("dot with nothing expected", o_dot_color, -1);
                end else begin
                    t_dot e;
                    e = dots_due.pop_front();
                    if (o_dot_color !== e.colour) begin
                        report_mismatch("dot_color", o_dot_color, e.colour);
                    end
                    if (o_last_dot !== e.last) begin
                        report_mismatch("last_dot", o_last_dot, e.last);
                    end
                end
                n_dots++;
                progress = 1'b1;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
            // Watchdog: give up after a long stretch with nothing moving
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic e);
        bytes_pending.push_back('{screen_byte: b, line_end: e});
        n_pushed++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: pick_byte = 8'h00;
            1: pick_byte = 8'hFF;
            2: pick_byte = 8'h7F;
            3: pick_byte = 8'h80 | (8'($urandom) & 8'h40);
            default: pick_byte = 8'($urandom);
        endcase
    endfunction

    // Random lines, mostly well formed; the last one may be left open
    task automatic queue_lines(input int total);
        int   left;
        int   len;
        bit   cut;
        logic e;
        left = total;
        while (left > 0) begin
            len = $urandom_range(12, 1);
            cut = (len > left);
            if (cut) len = left;
            for (int i = 0; i < len; i++) begin
                e = (i == len - 1) && !cut;
                // Noise: stray or missing line ends
                if ($urandom_range(15) == 0) e = 1'($urandom_range(1));
                push_byte(pick_byte(), e);
            end
            left -= len;
        end
    endtask

    // Overlong line: the length limit closes it at or before its marked end
    task automatic queue_overlong();
        int len;
        len = $urandom_range(LINE_BYTES + 4, LINE_BYTES);
        for (int i = 0; i < len; i++) begin
            push_byte(pick_byte(), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (n_bytes != n_pushed || dots_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int   idle_set[4];
        int   stall_set[4];
        logic mode_set[4];
        idle_set  = '{0, 56, 0, 34};
        stall_set = '{0, 0, 56, 34};
        mode_set  = '{MODE_MONO, MODE_NTSC, MODE_MONO, MODE_NTSC};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte lines at the extremes
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h7F, 1'b1);
        // Shift at line start, then shift carrying a set bit six
        push_byte(8'hC0, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h2A, 1'b0);
        push_byte(8'h55, 1'b1);
        // Walking one through every dot and the shift bit
        for (int i = 0; i < 8; i++) begin
            push_byte(8'h01 << i, i == 7);
        end
        push_byte(8'hD5, 1'b0);
        push_byte(8'hAA, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            repeat (20) @(posedge i_clk);
            write_mode(mode_set[p]);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            queue_lines(24);
            // Hold the sender until every dot so far has come out
            wait_drained();
            queue_overlong();
            queue_lines(24);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (dots_due.size() != 0) begin
            report_mismatch("dots never sent", 0, dots_due.size());
        end

        $display("Sent %0d screen bytes over %0d lines (%0d closed by length), checked %0d dots",
                 n_bytes, n_lines, n_forced, n_dots);
        $display("Mode written %0d times: %0d mono and %0d colour dots, four idling phases",
                 n_writes, n_mono, n_colour);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
